### rtl/point_rotate_reflect_3d_assert.svh
// Assertion macros shared by the point transform checker.
// Each macro expects clk and arst_n in scope and reports through $error.
`ifndef POINT_ROTATE_REFLECT_3D_ASSERT_SVH
`define POINT_ROTATE_REFLECT_3D_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRR_ASSERT_HOLD(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold at every clock edge out of reset.
`define PRR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

### rtl/prr_pkg.sv
// Shared constants and types of the point rotate/reflect pipeline.
// No dependencies; used by the top level and its checker.
`default_nettype none

package prr_pkg;

	// Pipeline depth from an accepted start to its done strobe.
	localparam int LAT = 73;
	localparam int NSTEP = 8;
	localparam int NROOT = 32;
	localparam int NQUO = 31;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [63:0] DEGEN_LEN2 = 64'd16384;

	// Register indexes on the configuration port (paddr[3:2]).
	localparam logic [1:0] REG_CX = 2'd0;
	localparam logic [1:0] REG_CY = 2'd1;
	localparam logic [1:0] REG_CZ = 2'd2;

	// Taylor term divisors n*(n+1) and reciprocals floor(2^33/d).
	localparam logic [8:0] SIN_DIV [NSTEP] = '{9'd6, 9'd20, 9'd42, 9'd72,
		9'd110, 9'd156, 9'd210, 9'd272};
	localparam logic [8:0] COS_DIV [NSTEP] = '{9'd2, 9'd12, 9'd30, 9'd56,
		9'd90, 9'd132, 9'd182, 9'd240};
	localparam logic [32:0] SIN_RCP [NSTEP] = '{
		33'((64'd1 << 33) / 64'd6), 33'((64'd1 << 33) / 64'd20),
		33'((64'd1 << 33) / 64'd42), 33'((64'd1 << 33) / 64'd72),
		33'((64'd1 << 33) / 64'd110), 33'((64'd1 << 33) / 64'd156),
		33'((64'd1 << 33) / 64'd210), 33'((64'd1 << 33) / 64'd272)};
	localparam logic [32:0] COS_RCP [NSTEP] = '{
		33'((64'd1 << 33) / 64'd2), 33'((64'd1 << 33) / 64'd12),
		33'((64'd1 << 33) / 64'd30), 33'((64'd1 << 33) / 64'd56),
		33'((64'd1 << 33) / 64'd90), 33'((64'd1 << 33) / 64'd132),
		33'((64'd1 << 33) / 64'd182), 33'((64'd1 << 33) / 64'd240)};

	typedef struct packed {
		logic             mode;
		logic             degen;
		logic [1:0]       quad;
		logic [2:0][31:0] pos;
		logic [2:0][32:0] dlt;
		logic [2:0][31:0] cen;
		logic [2:0][31:0] dir;
		logic [33:0]      sn;
		logic [33:0]      cs;
	} item_t;

endpackage

`default_nettype wire

### rtl/point_rotate_reflect_3d.sv
// Top level of the 3D point rotate/reflect pipeline.
// Depends on prr_pkg for constants, divisor tables and the item type.
`default_nettype none

// One point is taken per clock: busy never rises, and every beat accepted with
// start comes out as a one-cycle done strobe with out_x, out_y, out_z and status,
// in order. The receiver cannot hold results off. The latency
// is set by the reflection path: a 32-stage square root of the normal's squared
// length followed by a 31-stage restoring divider, one result bit per stage;
// the sine/cosine series runs alongside it in 24 stages. The centre registers
// are written over the APB port and must only change while no beat is in flight.
module point_rotate_reflect_3d (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	output logic              done,
	input  wire               mode,
	input  wire signed [31:0] pos_x,
	input  wire signed [31:0] pos_y,
	input  wire signed [31:0] pos_z,
	input  wire signed [31:0] dir_x,
	input  wire signed [31:0] dir_y,
	input  wire signed [31:0] dir_z,
	input  wire [15:0]        turn_fraction,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic              status,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [3:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int LAT = prr_pkg::LAT;
	localparam int NSTEP = prr_pkg::NSTEP;
	localparam int NROOT = prr_pkg::NROOT;
	localparam int NQUO = prr_pkg::NQUO;

	function automatic logic signed [35:0] mulr(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic [32:0] ma;
		logic [32:0] mb;
		logic [65:0] p;
		logic signed [35:0] r;
		ma = a[33] ? 33'(-a) : 33'(a);
		mb = b[33] ? 33'(-b) : 33'(b);
		p = 66'(ma) * 66'(mb) + (66'd1 << 29);
		r = $signed(36'(p[65:30]));
		return (a[33] ^ b[33]) ? -r : r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	// Configuration registers
	logic [31:0] cen_q [3];
	logic        wr_en;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q[0] <= '0;
			cen_q[1] <= '0;
			cen_q[2] <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				prr_pkg::REG_CX: cen_q[0] <= pwdata;
				prr_pkg::REG_CY: cen_q[1] <= pwdata;
				prr_pkg::REG_CZ: cen_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			prr_pkg::REG_CX: prdata = cen_q[0];
			prr_pkg::REG_CY: prdata = cen_q[1];
			prr_pkg::REG_CZ: prdata = cen_q[2];
			default:         prdata = '0;
		endcase
	end

	// Item line: valid bits and the per-beat data that travels along
	logic               vld_s [1:LAT];
	prr_pkg::item_t     car_s [1:LAT];
	prr_pkg::item_t     car2_c;
	prr_pkg::item_t     car29_c;
	logic signed [31:0] pos_in [3];
	logic signed [31:0] dir_in [3];
	logic [45:0]        xprod_s1;
	logic [63:0]        sq_s1 [3];
	logic [63:0]        len2_c;
	logic [30:0]        x_s2;
	logic [63:0]        len2_s2;
	logic [30:0]        x_s3;
	logic [31:0]        x2_s3;
	logic signed [34:0] sn_s28;
	logic signed [34:0] cs_s28;
	logic signed [34:0] qs_c;
	logic signed [34:0] qc_c;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;
	assign len2_c = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_comb begin
		unique case (car_s[28].quad)
			2'd0: begin qs_c = sn_s28;  qc_c = cs_s28;  end
			2'd1: begin qs_c = cs_s28;  qc_c = -sn_s28; end
			2'd2: begin qs_c = -sn_s28; qc_c = -cs_s28; end
			default: begin qs_c = -cs_s28; qc_c = sn_s28; end
		endcase
	end

	// Late fields are dropped in at the stage that produces them.
	always_comb begin
		car2_c = car_s[1];
		car2_c.degen = len2_c < prr_pkg::DEGEN_LEN2;
		car29_c = car_s[28];
		car29_c.sn = 34'(qs_c);
		car29_c.cs = 34'(qc_c);
	end

	always_ff @(posedge clk) begin
		car_s[1].mode <= mode;
		car_s[1].degen <= 1'b0;
		car_s[1].quad <= turn_fraction[15:14];
		car_s[1].sn <= '0;
		car_s[1].cs <= '0;
		for (int i = 0; i < 3; i++) begin
			car_s[1].pos[i] <= pos_in[i];
			car_s[1].cen[i] <= cen_q[i];
			car_s[1].dir[i] <= dir_in[i];
			car_s[1].dlt[i] <= 33'($signed(33'(pos_in[i])) - $signed(33'($signed(cen_q[i]))));
			sq_s1[i] <= 64'(mag32(dir_in[i])) * 64'(mag32(dir_in[i]));
		end
		xprod_s1 <= 46'(turn_fraction[13:0]) * 46'(prr_pkg::HALF_PI_Q30);
		for (int k = 3; k <= LAT; k++)
			if (k != 29) car_s[k] <= car_s[k-1];
		car_s[2] <= car2_c;
		car_s[29] <= car29_c;
	end

	always_ff @(posedge clk) begin
		x_s2 <= 31'((xprod_s1 + 46'd8192) >> 14);
		len2_s2 <= len2_c;
		x_s3 <= x_s2;
		x2_s3 <= 32'((62'(x_s2) * 62'(x_s2) + (62'd1 << 29)) >> 30);
	end

	// Sine and cosine series: each step is product, reciprocal, correction.
	logic [31:0]        st_in [NSTEP];
	logic [31:0]        ct_in [NSTEP];
	logic signed [34:0] ss_in [NSTEP];
	logic signed [34:0] cc_in [NSTEP];
	logic [31:0]        x2_in [NSTEP];
	logic [32:0]        sv_a [NSTEP];
	logic [32:0]        cv_a [NSTEP];
	logic signed [34:0] ss_a [NSTEP];
	logic signed [34:0] cc_a [NSTEP];
	logic [31:0]        x2_a [NSTEP];
	logic [32:0]        sv_b [NSTEP];
	logic [32:0]        cv_b [NSTEP];
	logic [32:0]        sq0_b [NSTEP];
	logic [32:0]        cq0_b [NSTEP];
	logic signed [34:0] ss_b [NSTEP];
	logic signed [34:0] cc_b [NSTEP];
	logic [31:0]        x2_b [NSTEP];
	logic [32:0]        srem [NSTEP];
	logic [32:0]        crem [NSTEP];
	logic [31:0]        st_c [NSTEP];
	logic [31:0]        ct_c [NSTEP];
	logic signed [34:0] ss_c [NSTEP];
	logic signed [34:0] cc_c [NSTEP];
	logic [31:0]        x2_c [NSTEP];

	always_comb begin
		st_in[0] = {1'b0, x_s3};
		ct_in[0] = 32'd1 << 30;
		ss_in[0] = '0;
		cc_in[0] = '0;
		x2_in[0] = x2_s3;
		for (int k = 1; k < NSTEP; k++) begin
			st_in[k] = st_c[k-1];
			ct_in[k] = ct_c[k-1];
			ss_in[k] = ss_c[k-1];
			cc_in[k] = cc_c[k-1];
			x2_in[k] = x2_c[k-1];
		end
		for (int k = 0; k < NSTEP; k++) begin
			srem[k] = sv_b[k] - 33'(42'(sq0_b[k]) * 42'(prr_pkg::SIN_DIV[k]));
			crem[k] = cv_b[k] - 33'(42'(cq0_b[k]) * 42'(prr_pkg::COS_DIV[k]));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTEP; k++) begin
			sv_a[k] <= 33'((64'(st_in[k]) * 64'(x2_in[k])) >> 30);
			cv_a[k] <= 33'((64'(ct_in[k]) * 64'(x2_in[k])) >> 30);
			// Series terms alternate in sign.
			if (k % 2 == 1) begin
				ss_a[k] <= ss_in[k] - $signed({3'b000, st_in[k]});
				cc_a[k] <= cc_in[k] - $signed({3'b000, ct_in[k]});
			end else begin
				ss_a[k] <= ss_in[k] + $signed({3'b000, st_in[k]});
				cc_a[k] <= cc_in[k] + $signed({3'b000, ct_in[k]});
			end
			x2_a[k] <= x2_in[k];

			sq0_b[k] <= 33'((66'(sv_a[k]) * 66'(prr_pkg::SIN_RCP[k])) >> 33);
			cq0_b[k] <= 33'((66'(cv_a[k]) * 66'(prr_pkg::COS_RCP[k])) >> 33);
			sv_b[k] <= sv_a[k];
			cv_b[k] <= cv_a[k];
			ss_b[k] <= ss_a[k];
			cc_b[k] <= cc_a[k];
			x2_b[k] <= x2_a[k];

			// The reciprocal estimate is at most one short of the floor.
			st_c[k] <= 32'(sq0_b[k] + 33'(srem[k] >= 33'(prr_pkg::SIN_DIV[k])));
			ct_c[k] <= 32'(cq0_b[k] + 33'(crem[k] >= 33'(prr_pkg::COS_DIV[k])));
			ss_c[k] <= ss_b[k];
			cc_c[k] <= cc_b[k];
			x2_c[k] <= x2_b[k];
		end
		sn_s28 <= ss_c[NSTEP-1] + $signed({3'b000, st_c[NSTEP-1]});
		cs_s28 <= cc_c[NSTEP-1] + $signed({3'b000, ct_c[NSTEP-1]});
	end

	// Square root of the squared normal length, two radicand bits per stage.
	logic [63:0] rt_v_s [NROOT];
	logic [33:0] rt_rem_s [NROOT];
	logic [31:0] rt_root_s [NROOT];
	logic [63:0] rv_in [NROOT];
	logic [33:0] rr_in [NROOT];
	logic [31:0] ro_in [NROOT];
	logic [35:0] rcur [NROOT];
	logic [35:0] rtry [NROOT];

	always_comb begin
		rv_in[0] = len2_s2;
		rr_in[0] = '0;
		ro_in[0] = '0;
		for (int j = 1; j < NROOT; j++) begin
			rv_in[j] = rt_v_s[j-1];
			rr_in[j] = rt_rem_s[j-1];
			ro_in[j] = rt_root_s[j-1];
		end
		for (int j = 0; j < NROOT; j++) begin
			rcur[j] = {rr_in[j], rv_in[j][63:62]};
			rtry[j] = 36'({ro_in[j], 2'b01});
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NROOT; j++) begin
			rt_v_s[j] <= rv_in[j] << 2;
			if (rcur[j] >= rtry[j]) begin
				rt_rem_s[j] <= 34'(rcur[j] - rtry[j]);
				rt_root_s[j] <= {ro_in[j][30:0], 1'b1};
			end else begin
				rt_rem_s[j] <= rcur[j][33:0];
				rt_root_s[j] <= {ro_in[j][30:0], 1'b0};
			end
		end
	end

	// Normalizing divide, three lanes, one quotient bit per stage.
	logic [61:0] nm_s35 [3];
	logic [31:0] dv_s35;
	logic [61:0] dn_s [NQUO][3];
	logic [31:0] dr_s [NQUO][3];
	logic [30:0] dq_s [NQUO][3];
	logic [31:0] dd_s [NQUO];
	logic [61:0] qn_in [NQUO][3];
	logic [31:0] qr_in [NQUO][3];
	logic [30:0] qq_in [NQUO][3];
	logic [31:0] qd_in [NQUO];
	logic [32:0] qt [NQUO][3];

	always_ff @(posedge clk) begin
		dv_s35 <= rt_root_s[NROOT-1];
		for (int i = 0; i < 3; i++)
			nm_s35[i] <= {mag32(car_s[34].dir[i]), 30'd0} + 62'(rt_root_s[NROOT-1] >> 1);
	end

	always_comb begin
		qd_in[0] = dv_s35;
		for (int i = 0; i < 3; i++) begin
			qn_in[0][i] = nm_s35[i];
			// The quotient stays below 2^31, so the top bits are below the divisor.
			qr_in[0][i] = {1'b0, nm_s35[i][61:31]};
			qq_in[0][i] = '0;
		end
		for (int j = 1; j < NQUO; j++) begin
			qd_in[j] = dd_s[j-1];
			for (int i = 0; i < 3; i++) begin
				qn_in[j][i] = dn_s[j-1][i];
				qr_in[j][i] = dr_s[j-1][i];
				qq_in[j][i] = dq_s[j-1][i];
			end
		end
		for (int j = 0; j < NQUO; j++)
			for (int i = 0; i < 3; i++)
				qt[j][i] = {qr_in[j][i], qn_in[j][i][NQUO-1-j]};
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NQUO; j++) begin
			dd_s[j] <= qd_in[j];
			for (int i = 0; i < 3; i++) begin
				dn_s[j][i] <= qn_in[j][i];
				if (qt[j][i] >= {1'b0, qd_in[j]}) begin
					dr_s[j][i] <= 32'(qt[j][i] - {1'b0, qd_in[j]});
					dq_s[j][i] <= qq_in[j][i] | (31'd1 << (NQUO - 1 - j));
				end else begin
					dr_s[j][i] <= qt[j][i][31:0];
					dq_s[j][i] <= qq_in[j][i];
				end
			end
		end
	end

	// Matrix build. Pair order: 00, 11, 22, 01, 02, 12.
	logic signed [31:0] u_s67 [3];
	logic signed [35:0] aa_s67 [6];
	logic signed [35:0] sa_s67 [3];
	logic signed [33:0] omc_s67;
	logic signed [33:0] c_s67;
	logic signed [35:0] uu_s68 [6];
	logic signed [35:0] t_s68 [6];
	logic signed [35:0] sa_s68 [3];
	logic signed [33:0] c_s68;
	logic signed [34:0] m_s69 [3][3];
	logic signed [34:0] mrot [3][3];
	logic signed [34:0] mref [3][3];
	logic [1:0]         pi_c [6];
	logic [1:0]         pj_c [6];

	assign pi_c = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	assign pj_c = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	always_ff @(posedge clk) begin
		omc_s67 <= (34'sd1 <<< 30) - $signed(car_s[66].cs);
		c_s67 <= $signed(car_s[66].cs);
		for (int i = 0; i < 3; i++) begin
			u_s67[i] <= car_s[66].dir[i][31] ? -$signed({1'b0, dq_s[NQUO-1][i]})
				: $signed({1'b0, dq_s[NQUO-1][i]});
			sa_s67[i] <= mulr($signed(car_s[66].sn),
				34'($signed(car_s[66].dir[i])));
		end
		for (int p = 0; p < 6; p++) begin
			aa_s67[p] <= mulr(34'($signed(car_s[66].dir[pi_c[p]])),
				34'($signed(car_s[66].dir[pj_c[p]])));
			uu_s68[p] <= mulr(34'(u_s67[pi_c[p]]), 34'(u_s67[pj_c[p]]));
			t_s68[p] <= mulr(omc_s67, 34'(aa_s67[p]));
		end
		sa_s68 <= sa_s67;
		c_s68 <= c_s67;
	end

	always_comb begin
		for (int p = 0; p < 3; p++)
			mrot[p][p] = 35'(37'(c_s68) + 37'(t_s68[p]));
		mrot[0][1] = 35'(t_s68[3] - sa_s68[2]);
		mrot[1][0] = 35'(t_s68[3] + sa_s68[2]);
		mrot[0][2] = 35'(t_s68[4] + sa_s68[1]);
		mrot[2][0] = 35'(t_s68[4] - sa_s68[1]);
		mrot[1][2] = 35'(t_s68[5] - sa_s68[0]);
		mrot[2][1] = 35'(t_s68[5] + sa_s68[0]);
		for (int p = 0; p < 6; p++) begin
			if (p < 3)
				mref[pi_c[p]][pj_c[p]] = 35'((37'sd1 <<< 30) - (37'(uu_s68[p]) <<< 1));
			else
				mref[pi_c[p]][pj_c[p]] = 35'(-(37'(uu_s68[p]) <<< 1));
			mref[pj_c[p]][pi_c[p]] = mref[pi_c[p]][pj_c[p]];
		end
	end

	always_ff @(posedge clk) begin
		m_s69 <= car_s[68].mode ? mref : mrot;
	end

	// Final sum: centre + M * (pos - centre), split products to bound width.
	logic signed [52:0] pl_s70 [3][3];
	logic signed [50:0] ph_s70 [3][3];
	logic signed [67:0] pr_s71 [3][3];
	logic signed [71:0] acc_s72 [3];
	logic signed [41:0] sh_c [3];
	logic signed [31:0] res_c [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pl_s70[i][j] <= m_s69[i][j] * $signed({1'b0, car_s[69].dlt[j][16:0]});
				ph_s70[i][j] <= m_s69[i][j] * $signed(car_s[69].dlt[j][32:17]);
				pr_s71[i][j] <= (68'(ph_s70[i][j]) <<< 17) + 68'(pl_s70[i][j]);
			end
			acc_s72[i] <= (72'($signed(car_s[71].cen[i])) <<< 30) + (72'sd1 <<< 29)
				+ 72'(pr_s71[i][0]) + 72'(pr_s71[i][1]) + 72'(pr_s71[i][2]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i] = acc_s72[i][71:30];
			if (sh_c[i][41:31] == {11{sh_c[i][31]}})
				res_c[i] = sh_c[i][31:0];
			else if (sh_c[i][41])
				res_c[i] = 32'sh8000_0000;
			else
				res_c[i] = 32'sh7fff_ffff;
			if (car_s[72].mode && car_s[72].degen)
				res_c[i] = $signed(car_s[72].pos[i]);
		end
	end

	always_ff @(posedge clk) begin
		out_x <= res_c[0];
		out_y <= res_c[1];
		out_z <= res_c[2];
		status <= car_s[72].mode && car_s[72].degen;
	end

	assign done = vld_s[LAT];

endmodule

`default_nettype wire

### rtl/prr_checker.sv
// Port-level checks on the point rotate/reflect block, bound to its top level.
// Depends on prr_pkg for the latency and on the assertion macro header.
`default_nettype none

`include "point_rotate_reflect_3d_assert.svh"

module prr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire        mode,
	input wire [31:0] pos_x,
	input wire [31:0] pos_y,
	input wire [31:0] pos_z,
	input wire [31:0] out_x,
	input wire [31:0] out_y,
	input wire [31:0] out_z,
	input wire        status
);

	// The pipeline never pushes back on start.
	`PRR_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

	// Every result beat goes back to a start beat a fixed latency earlier.
	`PRR_ASSERT_HOLD(a_done_has_start, done, $past(start, prr_pkg::LAT), "done without start")

	// A degenerate normal is only reported for a reflection.
	`PRR_ASSERT_HOLD(a_degen_refl, done && status, $past(mode, prr_pkg::LAT), "status in rotation")

	// A degenerate normal passes the point through untouched.
	`PRR_ASSERT_HOLD(a_degen_pass, done && status, out_x == $past(pos_x, prr_pkg::LAT) && out_y == $past(pos_y, prr_pkg::LAT) && out_z == $past(pos_z, prr_pkg::LAT), "point changed")

endmodule

bind point_rotate_reflect_3d prr_checker u_prr_checker (.*);

`default_nettype wire

### bench/point_rotate_reflect_3d_test.sv
// Self-checking bench for point_rotate_reflect_3d: random and directed points, centre changes
// over APB, with a bit-exact predictor of the rotate/reflect arithmetic.
// Depends on prr_pkg and the point_rotate_reflect_3d top level.
`timescale 1ns / 1ps

module point_rotate_reflect_3d_test;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic MODE_ROTATE = 1'b0;
	localparam logic MODE_REFLECT = 1'b1;

	typedef struct {
		logic               mode;
		logic signed [31:0] px, py, pz;
		logic signed [31:0] dx, dy, dz;
		logic [15:0]        turn;
	} point_job_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               status;
	} moved_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic mode = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [15:0] turn_fraction = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire busy, done, status, pready;
	wire signed [31:0] out_x, out_y, out_z;
	wire [31:0] prdata;

	point_rotate_reflect_3d u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .turn_fraction(turn_fraction),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	point_job_t   pending_jobs[$];
	moved_point_t expected_points[$];
	point_job_t   driven_job;
	logic signed [31:0] centre_x = '0, centre_y = '0, centre_z = '0;
	int idle_pct = 0;
	bit hold_sender = 1'b0;
	int err_count = 0;
	int n_rot = 0, n_refl = 0, n_degen = 0, n_checked = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
		input logic signed [31:0] want);
		$display("%0t ns: MISMATCH %s got %0d expected %0d", $time, what, got, want);
		err_count++;
	endtask

	function automatic longint unsigned magnitude(input longint a);
		return a < 0 ? longint'(0) - a : a;
	endfunction

	// Q.30 product, rounded to nearest with ties away from zero.
	function automatic longint q30_mul(input longint a, input longint b);
		longint unsigned p;
		p = (magnitude(a) * magnitude(b) + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Taylor series per quadrant, each term truncated as the hardware does.
	function automatic void sine_cosine(input logic [15:0] t, output longint s, output longint c);
		longint unsigned r, x, x2, term;
		longint sn, cs;
		int n;
		r = t[13:0];
		x = (r * 64'(prr_pkg::HALF_PI_Q30) + (64'd1 << 13)) >> 14;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		sn = 0;
		term = x;
		for (n = 1; n <= 17; n += 2) begin
			sn += ((n >> 1) & 1) ? -longint'(term) : longint'(term);
			term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
		end
		cs = 0;
		term = 64'd1 << 30;
		for (n = 0; n <= 16; n += 2) begin
			cs += ((n >> 1) & 1) ? -longint'(term) : longint'(term);
			term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
		end
		case (t[15:14])
			2'd0: begin s = sn; c = cs; end
			2'd1: begin s = cs; c = -sn; end
			2'd2: begin s = -sn; c = -cs; end
			default: begin s = -cs; c = sn; end
		endcase
	endfunction

	// centre + row . delta, with the sum kept exact, rounded half up and saturated.
	function automatic logic signed [31:0] settle_coord(input longint cen, input longint m0,
		input longint m1, input longint m2, input longint d0, input longint d1, input longint d2);
		logic signed [127:0] acc, t0, t1, t2;
		acc = cen;
		acc = acc <<< 30;
		t0 = m0; t1 = m1; t2 = m2;
		acc = acc + t0 * d0 + t1 * d1 + t2 * d2 + (128'sd1 <<< 29);
		acc = acc >>> 30;
		if (acc > 128'sd2147483647) return 32'sh7fffffff;
		if (acc < -128'sd2147483648) return 32'sh80000000;
		return acc[31:0];
	endfunction

	function automatic moved_point_t transform_point(input point_job_t j);
		moved_point_t res;
		longint p[3], a[3], cen[3], d[3], m[3][3], u[3];
		longint s, c, omc;
		longint unsigned len2, r, qv;
		p[0] = j.px; p[1] = j.py; p[2] = j.pz;
		a[0] = j.dx; a[1] = j.dy; a[2] = j.dz;
		cen[0] = centre_x; cen[1] = centre_y; cen[2] = centre_z;
		for (int i = 0; i < 3; i++) d[i] = p[i] - cen[i];
		res.status = 1'b0;
		if (j.mode == MODE_ROTATE) begin
			sine_cosine(j.turn, s, c);
			omc = (64'sd1 <<< 30) - c;
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					m[i][k] = q30_mul(omc, q30_mul(a[i], a[k]));
			for (int i = 0; i < 3; i++) m[i][i] += c;
			m[0][1] -= q30_mul(s, a[2]); m[1][0] += q30_mul(s, a[2]);
			m[0][2] += q30_mul(s, a[1]); m[2][0] -= q30_mul(s, a[1]);
			m[1][2] -= q30_mul(s, a[0]); m[2][1] += q30_mul(s, a[0]);
		end else begin
			len2 = 0;
			for (int i = 0; i < 3; i++) len2 += magnitude(a[i]) * magnitude(a[i]);
			if (len2 < prr_pkg::DEGEN_LEN2) begin
				res.x = j.px; res.y = j.py; res.z = j.pz;
				res.status = 1'b1;
				return res;
			end
			r = floor_sqrt(len2);
			for (int i = 0; i < 3; i++) begin
				qv = ((magnitude(a[i]) << 30) + (r >> 1)) / r;
				u[i] = a[i] < 0 ? -longint'(qv) : longint'(qv);
			end
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					m[i][k] = (i == k ? (64'sd1 <<< 30) : 64'sd0) - 2 * q30_mul(u[i], u[k]);
		end
		res.x = settle_coord(cen[0], m[0][0], m[0][1], m[0][2], d[0], d[1], d[2]);
		res.y = settle_coord(cen[1], m[1][0], m[1][1], m[1][2], d[0], d[1], d[2]);
		res.z = settle_coord(cen[2], m[2][0], m[2][1], m[2][2], d[0], d[1], d[2]);
		return res;
	endfunction

	// Driver: the beat on the ports is taken when start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_points.push_back(transform_point(driven_job));
				if (driven_job.mode == MODE_ROTATE) n_rot++;
				else n_refl++;
			end
			if (!start || !busy) begin
				if (pending_jobs.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
					driven_job <= pending_jobs[0];
					mode <= pending_jobs[0].mode;
					pos_x <= pending_jobs[0].px;
					pos_y <= pending_jobs[0].py;
					pos_z <= pending_jobs[0].pz;
					dir_x <= pending_jobs[0].dx;
					dir_y <= pending_jobs[0].dy;
					dir_z <= pending_jobs[0].dz;
					turn_fraction <= pending_jobs[0].turn;
					void'(pending_jobs.pop_front());
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		moved_point_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_points.size() == 0) begin
					report_mismatch("done with nothing outstanding", 32'sd1, 32'sd0);
				end else begin
					want = expected_points.pop_front();
					n_checked++;
					if (want.status == 1'b1) n_degen++;
					if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
					if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
					if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
					if (status !== want.status) report_mismatch("status", status, want.status);
				end
			end
			if (done || (start && !busy) || (psel && penable)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("point_rotate_reflect_3d_test failed");
				$finish;
			end
		end
	end

	task automatic write_centre(input logic [1:0] idx, input logic signed [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			prr_pkg::REG_CX: centre_x = value;
			prr_pkg::REG_CY: centre_y = value;
			prr_pkg::REG_CZ: centre_z = value;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_jobs.size() != 0 || start || expected_points.size() != 0);
	endtask

	task automatic add_job(input logic md, input logic signed [31:0] px, py, pz,
		input logic signed [31:0] dx, dy, dz, input logic [15:0] tf);
		point_job_t j;
		j.mode = md; j.px = px; j.py = py; j.pz = pz;
		j.dx = dx; j.dy = dy; j.dz = dz; j.turn = tf;
		pending_jobs.push_back(j);
	endtask

	function automatic void unit_axis(output logic signed [31:0] ux, uy, uz);
		real vx, vy, vz, len;
		do begin
			vx = real'(int'($urandom_range(2000)) - 1000);
			vy = real'(int'($urandom_range(2000)) - 1000);
			vz = real'(int'($urandom_range(2000)) - 1000);
			len = $sqrt(vx * vx + vy * vy + vz * vz);
		end while (len < 10.0);
		ux = $rtoi(vx / len * 1073741824.0);
		uy = $rtoi(vy / len * 1073741824.0);
		uz = $rtoi(vz / len * 1073741824.0);
	endfunction

	task automatic add_random_job();
		int kind;
		logic md;
		logic signed [31:0] px, py, pz, dx, dy, dz;
		kind = $urandom_range(99);
		md = $urandom_range(1);
		px = $signed($urandom) >>> 8;
		py = $signed($urandom) >>> 8;
		pz = $signed($urandom) >>> 8;
		unit_axis(dx, dy, dz);
		if (kind >= 60 && kind < 75) begin
			px = $urandom; py = $urandom; pz = $urandom;
		end else if (kind >= 75 && kind < 90) begin
			px = $urandom; py = $urandom; pz = $urandom;
			dx = $urandom; dy = $urandom; dz = $urandom;
		end else if (kind >= 90 && kind < 95) begin
			// Normals around the degenerate threshold.
			md = MODE_REFLECT;
			dx = int'($urandom_range(160)) - 80;
			dy = int'($urandom_range(160)) - 80;
			dz = int'($urandom_range(160)) - 80;
		end else if (kind >= 95) begin
			dx = $signed(dx) >>> $urandom_range(3);
			dy = $signed(dy) <<< $urandom_range(1);
		end
		add_job(md, px, py, pz, dx, dy, dz, 16'($urandom));
	endtask

	initial begin
		logic signed [31:0] centres[4][3];
		int idles[4];
		idles = '{0, 73, 0, 10};
		centres[0] = '{32'sd0, 32'sd0, 32'sd0};
		centres[1] = '{32'sh7fffffff, 32'sh80000000, 32'sd0};
		centres[2] = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_centre(prr_pkg::REG_CX, 32'sd65536);
		write_centre(prr_pkg::REG_CY, -32'sd131072);
		write_centre(prr_pkg::REG_CZ, 32'sd12345);
		write_centre(REG_UNUSED, 32'hdeadbeef);

		// Directed: quadrant angles, extremes, saturation and degenerate normals.
		add_job(MODE_ROTATE, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1073741824, 16'd0);
		add_job(MODE_ROTATE, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1073741824, 16'd16384);
		add_job(MODE_ROTATE, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1073741824, 16'd32768);
		add_job(MODE_ROTATE, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1073741824, 16'd49152);
		add_job(MODE_ROTATE, 32'sd65536, 32'sd7, -32'sd9, 32'sd1073741824, 32'sd0, 32'sd0, 16'd65535);
		add_job(MODE_ROTATE, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sd0, 32'sd0, 32'sd1073741824, 16'd32768);
		add_job(MODE_ROTATE, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'd8191);
		add_job(MODE_ROTATE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 16'd40000);
		add_job(MODE_ROTATE, 32'sd1000, 32'sd2000, 32'sd3000, 32'sd0, 32'sd0, 32'sd0, 16'd12345);
		add_job(MODE_ROTATE, 32'sd1000, 32'sd2000, 32'sd3000,
			32'sd536870912, 32'sd0, 32'sd0, 16'd5000);
		add_job(MODE_REFLECT, 32'sd65536, 32'sd131072, -32'sd65536,
			32'sd1073741824, 32'sd0, 32'sd0, 16'd0);
		add_job(MODE_REFLECT, 32'sd65536, 32'sd131072, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'd7);
		add_job(MODE_REFLECT, 32'sd5, 32'sd6, 32'sd7, 32'sd100, 32'sd0, 32'sd0, 16'd0);
		add_job(MODE_REFLECT, 32'sd5, 32'sd6, 32'sd7, 32'sd128, 32'sd0, 32'sd0, 16'd0);
		add_job(MODE_REFLECT, 32'sd5, 32'sd6, 32'sd7, 32'sd73, 32'sd73, 32'sd73, 16'd0);
		add_job(MODE_REFLECT, 32'sd5, 32'sd6, 32'sd7, -32'sd74, 32'sd74, -32'sd74, 16'd0);
		add_job(MODE_REFLECT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 16'hffff);
		add_job(MODE_REFLECT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sd1, 16'd0);
		add_job(MODE_REFLECT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sd759250125, 32'sd759250125, 32'sd0, 16'd0);
		add_job(MODE_REFLECT, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 16'd0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph < 3) begin
				write_centre(prr_pkg::REG_CX, centres[ph][0]);
				write_centre(prr_pkg::REG_CY, centres[ph][1]);
				write_centre(prr_pkg::REG_CZ, centres[ph][2]);
			end else begin
				write_centre(prr_pkg::REG_CX, $urandom);
				write_centre(prr_pkg::REG_CY, $signed($urandom) >>> 8);
				write_centre(prr_pkg::REG_CZ, $signed($urandom) >>> 12);
			end
			idle_pct = idles[ph];
			for (int k = 0; k < 132; k++) add_random_job();
			if (ph == 1) begin
				// Let the pipeline run dry before the rest of the phase goes in.
				repeat (40) @(negedge clk);
				hold_sender = 1'b1;
				while (start || expected_points.size() != 0) @(negedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end

		repeat (prr_pkg::LAT + 20) @(negedge clk);
		$display("covered %0d rotations and %0d reflections (%0d degenerate) over 5 centre settings",
			n_rot, n_refl, n_degen);
		$display("%0d results checked, %0d mismatches", n_checked, err_count);
		if (err_count == 0 && expected_points.size() == 0) begin
			$display("point_rotate_reflect_3d_test passed");
		end else begin
			$display("point_rotate_reflect_3d_test failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/prr_pkg.sv
rtl/point_rotate_reflect_3d.sv
rtl/prr_checker.sv
bench/point_rotate_reflect_3d_test.sv
